>>> rtl/yuvbgr_pkg.sv
// Shared types and constants for the YUV 4:2:2 to BGR converter.
package yuvbgr_pkg;

  // Placement of the luma and chroma samples among the four input bytes.
  typedef enum logic [1:0] {
    BO_Y0_CB_Y1_CR = 2'd0,
    BO_Y0_CR_Y1_CB = 2'd1,
    BO_CB_Y0_CR_Y1 = 2'd2,
    BO_CR_Y0_CB_Y1 = 2'd3
  } byte_order_e;

  localparam int unsigned PixW  = 8;
  // Offset luma is -16..239 and offset chroma is -128..127.
  localparam int unsigned LumaW = 9;
  localparam int unsigned ChrW  = 8;
  // Every weighted sum stays within -276928..534482.
  localparam int unsigned SumW  = 21;

  localparam logic [PixW-1:0] LumaOffset = 8'd16;

  localparam logic signed [SumW-1:0] CoefY    = 21'sd1164;
  localparam logic signed [SumW-1:0] CoefCbB  = 21'sd2018;
  localparam logic signed [SumW-1:0] CoefCrR  = 21'sd1596;
  localparam logic signed [SumW-1:0] CoefYG   = 21'sd1192;
  localparam logic signed [SumW-1:0] CoefCrG  = 21'sd832;
  localparam logic signed [SumW-1:0] CoefCbG  = 21'sd400;

  // Division by 1000 as a multiply by ceil(2^28/1000); exact for sums below 2^18.
  localparam int unsigned DivInW    = 18;
  localparam int unsigned RecipW    = 19;
  localparam int unsigned RecipShift = 28;
  localparam logic [RecipW-1:0] Recip1000 = 19'd268436;
  // Sums at or above this value floor to 256 or more after the division.
  localparam logic signed [SumW-1:0] ChromaSat = 21'sd256000;
  localparam int unsigned GreenShift = 10;

  localparam logic [PixW-1:0] PixMax = 8'd255;

  typedef struct packed {
    logic sum_en;
    logic out_en;
  } lane_ctrl_t;

endpackage

>>> rtl/yuvbgr_unpack.sv
// Input stage: picks luma and chroma samples by byte order and removes their offsets.
module yuvbgr_unpack (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  yuvbgr_pkg::byte_order_e                byte_order_i,
  input  logic [yuvbgr_pkg::PixW-1:0]            byte_first_i,
  input  logic [yuvbgr_pkg::PixW-1:0]            byte_second_i,
  input  logic [yuvbgr_pkg::PixW-1:0]            byte_third_i,
  input  logic [yuvbgr_pkg::PixW-1:0]            byte_fourth_i,
  output logic signed [yuvbgr_pkg::LumaW-1:0]    dy0_o,
  output logic signed [yuvbgr_pkg::LumaW-1:0]    dy1_o,
  output logic signed [yuvbgr_pkg::ChrW-1:0]     du_o,
  output logic signed [yuvbgr_pkg::ChrW-1:0]     dv_o
);

  logic [yuvbgr_pkg::PixW-1:0] y0, y1, cb, cr;
  logic signed [yuvbgr_pkg::LumaW-1:0] dy0_d, dy1_d, dy0_q, dy1_q;
  logic signed [yuvbgr_pkg::ChrW-1:0]  du_d, dv_d, du_q, dv_q;

  always_comb begin
    case (byte_order_i)
      yuvbgr_pkg::BO_Y0_CB_Y1_CR: begin
        y0 = byte_first_i;  cb = byte_second_i; y1 = byte_third_i;  cr = byte_fourth_i;
      end
      yuvbgr_pkg::BO_Y0_CR_Y1_CB: begin
        y0 = byte_first_i;  cr = byte_second_i; y1 = byte_third_i;  cb = byte_fourth_i;
      end
      yuvbgr_pkg::BO_CB_Y0_CR_Y1: begin
        cb = byte_first_i;  y0 = byte_second_i; cr = byte_third_i;  y1 = byte_fourth_i;
      end
      default: begin
        cr = byte_first_i;  y0 = byte_second_i; cb = byte_third_i;  y1 = byte_fourth_i;
      end
    endcase
    dy0_d = $signed({1'b0, y0}) - $signed({1'b0, yuvbgr_pkg::LumaOffset});
    dy1_d = $signed({1'b0, y1}) - $signed({1'b0, yuvbgr_pkg::LumaOffset});
    // Subtracting 128 from an unsigned byte is a flip of its top bit.
    du_d  = $signed({~cb[yuvbgr_pkg::PixW-1], cb[yuvbgr_pkg::PixW-2:0]});
    dv_d  = $signed({~cr[yuvbgr_pkg::PixW-1], cr[yuvbgr_pkg::PixW-2:0]});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dy0_q <= dy0_d;
      dy1_q <= dy1_d;
      du_q  <= du_d;
      dv_q  <= dv_d;
    end
  end

  assign dy0_o = dy0_q;
  assign dy1_o = dy1_q;
  assign du_o  = du_q;
  assign dv_o  = dv_q;

endmodule

>>> rtl/yuvbgr_lane.sv
// One pixel lane: weighted sums in one stage, scaling and clamping in the next.
module yuvbgr_lane (
  input  logic                                clk_i,
  input  yuvbgr_pkg::lane_ctrl_t              ctrl_i,
  input  logic signed [yuvbgr_pkg::LumaW-1:0] dy_i,
  input  logic signed [yuvbgr_pkg::ChrW-1:0]  du_i,
  input  logic signed [yuvbgr_pkg::ChrW-1:0]  dv_i,
  output logic [yuvbgr_pkg::PixW-1:0]         blue_o,
  output logic [yuvbgr_pkg::PixW-1:0]         green_o,
  output logic [yuvbgr_pkg::PixW-1:0]         red_o
);

  localparam int unsigned SumW = yuvbgr_pkg::SumW;
  localparam int unsigned ProdW = yuvbgr_pkg::DivInW + yuvbgr_pkg::RecipW;

  logic signed [SumW-1:0] dy_x, du_x, dv_x;
  logic signed [SumW-1:0] sum_b_d, sum_g_d, sum_r_d;
  logic signed [SumW-1:0] sum_b_q, sum_g_q, sum_r_q;
  logic [ProdW-1:0] prod_b, prod_r;
  logic [yuvbgr_pkg::PixW-1:0] blue_d, green_d, red_d;
  logic [yuvbgr_pkg::PixW-1:0] blue_q, green_q, red_q;

  always_comb begin
    dy_x = SumW'(dy_i);
    du_x = SumW'(du_i);
    dv_x = SumW'(dv_i);
    sum_b_d = yuvbgr_pkg::CoefY * dy_x + yuvbgr_pkg::CoefCbB * du_x;
    sum_r_d = yuvbgr_pkg::CoefY * dy_x + yuvbgr_pkg::CoefCrR * dv_x;
    sum_g_d = yuvbgr_pkg::CoefYG * dy_x - yuvbgr_pkg::CoefCrG * dv_x
              - yuvbgr_pkg::CoefCbG * du_x;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      sum_b_q <= sum_b_d;
      sum_g_q <= sum_g_d;
      sum_r_q <= sum_r_d;
    end
  end

  always_comb begin
    prod_b = ProdW'(sum_b_q[yuvbgr_pkg::DivInW-1:0]) * ProdW'(yuvbgr_pkg::Recip1000);
    prod_r = ProdW'(sum_r_q[yuvbgr_pkg::DivInW-1:0]) * ProdW'(yuvbgr_pkg::Recip1000);

    if (sum_b_q[SumW-1]) begin
      blue_d = '0;
    end else if (sum_b_q >= yuvbgr_pkg::ChromaSat) begin
      blue_d = yuvbgr_pkg::PixMax;
    end else begin
      blue_d = prod_b[yuvbgr_pkg::RecipShift +: yuvbgr_pkg::PixW];
    end

    if (sum_r_q[SumW-1]) begin
      red_d = '0;
    end else if (sum_r_q >= yuvbgr_pkg::ChromaSat) begin
      red_d = yuvbgr_pkg::PixMax;
    end else begin
      red_d = prod_r[yuvbgr_pkg::RecipShift +: yuvbgr_pkg::PixW];
    end

    // A non-negative sum whose bits above the shifted byte are set saturates.
    if (sum_g_q[SumW-1]) begin
      green_d = '0;
    end else if (|sum_g_q[SumW-2:yuvbgr_pkg::GreenShift + yuvbgr_pkg::PixW]) begin
      green_d = yuvbgr_pkg::PixMax;
    end else begin
      green_d = sum_g_q[yuvbgr_pkg::GreenShift +: yuvbgr_pkg::PixW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_en) begin
      blue_q  <= blue_d;
      green_q <= green_d;
      red_q   <= red_d;
    end
  end

  assign blue_o  = blue_q;
  assign green_o = green_q;
  assign red_o   = red_q;

endmodule

>>> rtl/yuv422_to_bgr_converter_core.sv
// Top level: byte order register, stage control, the unpack stage and the two pixel lanes.
// An accepted item passes the unpack, sum and output registers on its way to the output.
// Throughput is one item per cycle while the output is not stalled; each of the three
// stages holds an item and advances as soon as the stage after it is empty or moving.
// Reset clears the stage valid flags and sets the byte order to Y0 Cb Y1 Cr.
module yuv422_to_bgr_converter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [yuvbgr_pkg::PixW-1:0]   byte_first_i,
  input  logic [yuvbgr_pkg::PixW-1:0]   byte_second_i,
  input  logic [yuvbgr_pkg::PixW-1:0]   byte_third_i,
  input  logic [yuvbgr_pkg::PixW-1:0]   byte_fourth_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [yuvbgr_pkg::PixW-1:0]   blue_left_o,
  output logic [yuvbgr_pkg::PixW-1:0]   green_left_o,
  output logic [yuvbgr_pkg::PixW-1:0]   red_left_o,
  output logic [yuvbgr_pkg::PixW-1:0]   blue_right_o,
  output logic [yuvbgr_pkg::PixW-1:0]   green_right_o,
  output logic [yuvbgr_pkg::PixW-1:0]   red_right_o
);

  yuvbgr_pkg::byte_order_e byte_order_q;
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  yuvbgr_pkg::lane_ctrl_t lane_ctrl;
  logic signed [yuvbgr_pkg::LumaW-1:0] dy0, dy1;
  logic signed [yuvbgr_pkg::ChrW-1:0]  du, dv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_order_q <= yuvbgr_pkg::BO_Y0_CB_Y1_CR;
    end else if (cfg_valid_i) begin
      byte_order_q <= yuvbgr_pkg::byte_order_e'(cfg_data_i);
    end
  end

  // A stage loads when it is empty or its item moves on in the same cycle.
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  assign lane_ctrl.sum_en = en2;
  assign lane_ctrl.out_en = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  assign out_valid_o = v3_q;

  yuvbgr_unpack u_unpack (
    .clk_i         (clk_i),
    .en_i          (en1),
    .byte_order_i  (byte_order_q),
    .byte_first_i  (byte_first_i),
    .byte_second_i (byte_second_i),
    .byte_third_i  (byte_third_i),
    .byte_fourth_i (byte_fourth_i),
    .dy0_o         (dy0),
    .dy1_o         (dy1),
    .du_o          (du),
    .dv_o          (dv)
  );

  yuvbgr_lane u_lane_left (
    .clk_i   (clk_i),
    .ctrl_i  (lane_ctrl),
    .dy_i    (dy0),
    .du_i    (du),
    .dv_i    (dv),
    .blue_o  (blue_left_o),
    .green_o (green_left_o),
    .red_o   (red_left_o)
  );

  yuvbgr_lane u_lane_right (
    .clk_i   (clk_i),
    .ctrl_i  (lane_ctrl),
    .dy_i    (dy1),
    .du_i    (du),
    .dv_i    (dv),
    .blue_o  (blue_right_o),
    .green_o (green_right_o),
    .red_o   (red_right_o)
  );

endmodule

>>> bench/yuv422_to_bgr_converter_core_tb.sv
// Self-checking testbench for the YUV 4:2:2 to BGR converter core.
`timescale 1ns / 1ps

module yuv422_to_bgr_converter_core_tb;

  localparam int unsigned LatencyCycles = 3;
  localparam int unsigned CycleLimit    = 400000;

  typedef struct packed {
    logic [yuvbgr_pkg::PixW-1:0] blue_l;
    logic [yuvbgr_pkg::PixW-1:0] green_l;
    logic [yuvbgr_pkg::PixW-1:0] red_l;
    logic [yuvbgr_pkg::PixW-1:0] blue_r;
    logic [yuvbgr_pkg::PixW-1:0] green_r;
    logic [yuvbgr_pkg::PixW-1:0] red_r;
  } bgr_pair_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [1:0]                  cfg_data_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [yuvbgr_pkg::PixW-1:0] byte_first_i;
  logic [yuvbgr_pkg::PixW-1:0] byte_second_i;
  logic [yuvbgr_pkg::PixW-1:0] byte_third_i;
  logic [yuvbgr_pkg::PixW-1:0] byte_fourth_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [yuvbgr_pkg::PixW-1:0] blue_left_o;
  logic [yuvbgr_pkg::PixW-1:0] green_left_o;
  logic [yuvbgr_pkg::PixW-1:0] red_left_o;
  logic [yuvbgr_pkg::PixW-1:0] blue_right_o;
  logic [yuvbgr_pkg::PixW-1:0] green_right_o;
  logic [yuvbgr_pkg::PixW-1:0] red_right_o;

  yuvbgr_pkg::byte_order_e order_model;
  bgr_pair_t   pending_pixels[$];
  bit          no_idle;
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned sent_count;
  int unsigned received_count;
  int unsigned order_writes;
  int unsigned stalled_cycles;

  yuv422_to_bgr_converter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_first_i  (byte_first_i),
    .byte_second_i (byte_second_i),
    .byte_third_i  (byte_third_i),
    .byte_fourth_i (byte_fourth_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .blue_left_o   (blue_left_o),
    .green_left_o  (green_left_o),
    .red_left_o    (red_left_o),
    .blue_right_o  (blue_right_o),
    .green_right_o (green_right_o),
    .red_right_o   (red_right_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Blue and red: exact thousandths, floored, then clamped.
  function automatic logic [yuvbgr_pkg::PixW-1:0] chroma_weighted(int dy, int dc, int coef);
    int sum;
    int quot;
    sum = 1164 * dy + coef * dc;
    if (sum < 0) return '0;
    quot = sum / 1000;
    return (quot > 255) ? yuvbgr_pkg::PixMax : quot[yuvbgr_pkg::PixW-1:0];
  endfunction

  function automatic logic [yuvbgr_pkg::PixW-1:0] green_weighted(int dy, int du, int dv);
    int sum;
    int shifted;
    sum = 1192 * dy - 832 * dv - 400 * du;
    if (sum < 0) return '0;
    shifted = sum >>> 10;
    return (shifted > 255) ? yuvbgr_pkg::PixMax : shifted[yuvbgr_pkg::PixW-1:0];
  endfunction

  function automatic bgr_pair_t convert_macropixel(yuvbgr_pkg::byte_order_e order,
                                                   logic [yuvbgr_pkg::PixW-1:0] b0,
                                                   logic [yuvbgr_pkg::PixW-1:0] b1,
                                                   logic [yuvbgr_pkg::PixW-1:0] b2,
                                                   logic [yuvbgr_pkg::PixW-1:0] b3);
    int y0;
    int y1;
    int cb;
    int cr;
    int du;
    int dv;
    bgr_pair_t px;
    case (order)
      yuvbgr_pkg::BO_Y0_CB_Y1_CR: begin y0 = b0; cb = b1; y1 = b2; cr = b3; end
      yuvbgr_pkg::BO_Y0_CR_Y1_CB: begin y0 = b0; cr = b1; y1 = b2; cb = b3; end
      yuvbgr_pkg::BO_CB_Y0_CR_Y1: begin cb = b0; y0 = b1; cr = b2; y1 = b3; end
      default:                    begin cr = b0; y0 = b1; cb = b2; y1 = b3; end
    endcase
    du = cb - 128;
    dv = cr - 128;
    px.blue_l  = chroma_weighted(y0 - 16, du, 2018);
    px.green_l = green_weighted(y0 - 16, du, dv);
    px.red_l   = chroma_weighted(y0 - 16, dv, 1596);
    px.blue_r  = chroma_weighted(y1 - 16, du, 2018);
    px.green_r = green_weighted(y1 - 16, du, dv);
    px.red_r   = chroma_weighted(y1 - 16, dv, 1596);
    return px;
  endfunction

  // Half full-range bytes, with a share of video-legal levels and the extremes.
  function automatic logic [yuvbgr_pkg::PixW-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2, 3, 4: return 8'($urandom_range(16, 240));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [yuvbgr_pkg::PixW-1:0] b0, logic [yuvbgr_pkg::PixW-1:0] b1,
                           logic [yuvbgr_pkg::PixW-1:0] b2, logic [yuvbgr_pkg::PixW-1:0] b3);
    int gap;
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    byte_first_i  <= b0;
    byte_second_i <= b1;
    byte_third_i  <= b2;
    byte_fourth_i <= b3;
    do @(posedge clk_i); while (in_stall_o);
    pending_pixels.push_back(convert_macropixel(order_model, b0, b1, b2, b3));
    sent_count++;
  endtask

  task automatic send_random_items(int unsigned count);
    repeat (count) send_item(pick_byte(), pick_byte(), pick_byte(), pick_byte());
  endtask

  // Drops valid and waits until every pending item has come out.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 1) @(posedge clk_i);
  endtask

  task automatic write_byte_order(yuvbgr_pkg::byte_order_e order);
    drain_pipeline();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= order;
    do @(posedge clk_i); while (!cfg_ready_o);
    order_model = order;
    order_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // The register is left at its reset value here.
  task automatic test_reset_order();
    send_item(8'd0, 8'd0, 8'd0, 8'd0);
    send_item(8'd255, 8'd255, 8'd255, 8'd255);
    send_item(8'd16, 8'd128, 8'd16, 8'd128);
    send_item(8'd235, 8'd128, 8'd235, 8'd128);
    send_item(8'd255, 8'd0, 8'd255, 8'd0);
    send_item(8'd0, 8'd255, 8'd0, 8'd255);
    send_item(8'd128, 8'd255, 8'd128, 8'd0);
    send_item(8'd128, 8'd0, 8'd128, 8'd255);
    send_item(8'hAA, 8'h55, 8'h55, 8'hAA);
    send_item(8'h55, 8'hAA, 8'hAA, 8'h55);
  endtask

  task automatic test_other_orders();
    yuvbgr_pkg::byte_order_e orders[3];
    orders = '{yuvbgr_pkg::BO_CR_Y0_CB_Y1, yuvbgr_pkg::BO_Y0_CR_Y1_CB,
               yuvbgr_pkg::BO_CB_Y0_CR_Y1};
    foreach (orders[i]) begin
      write_byte_order(orders[i]);
      send_item(8'd0, 8'd255, 8'd128, 8'd16);
      send_item(8'd255, 8'd0, 8'd16, 8'd235);
      send_random_items(2);
    end
  endtask

  task automatic test_random_phases();
    yuvbgr_pkg::byte_order_e orders[5];
    orders = '{yuvbgr_pkg::BO_Y0_CB_Y1_CR, yuvbgr_pkg::BO_CR_Y0_CB_Y1,
               yuvbgr_pkg::BO_Y0_CR_Y1_CB, yuvbgr_pkg::BO_CB_Y0_CR_Y1,
               yuvbgr_pkg::byte_order_e'($urandom_range(0, 3))};
    foreach (orders[i]) begin
      write_byte_order(orders[i]);
      send_random_items(180);
    end
  endtask

  // Back-to-back items with output stalls turned off.
  task automatic test_full_rate();
    write_byte_order(yuvbgr_pkg::byte_order_e'($urandom_range(0, 3)));
    no_idle = 1'b1;
    send_random_items(100);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    byte_first_i  = '0;
    byte_second_i = '0;
    byte_third_i  = '0;
    byte_fourth_i = '0;
    order_model   = yuvbgr_pkg::BO_Y0_CB_Y1_CR;
    no_idle       = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_order();
    test_other_orders();
    test_random_phases();
    test_full_rate();
    drain_pipeline();
    repeat (2 * LatencyCycles) @(posedge clk_i);

    $display("Converted %0d macropixels (%0d checked) across %0d byte order writes.",
             sent_count, received_count, order_writes);
    $display("Output was held off for %0d cycles; %0d mismatches.",
             stalled_cycles, err_count);
    if (err_count == 0) begin
      $display("[yuv422_to_bgr_converter_core] OK");
    end else begin
      $display("[yuv422_to_bgr_converter_core] ERROR");
    end
    $finish;
  end

  // Output hold-off: random bursts, long free stretches, none at full rate.
  initial begin : stall_gen
    int run;
    out_stall_i = 1'b0;
    forever begin
      if (no_idle) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        run = $urandom_range(1, 19);
        repeat (run) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else begin
        run = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 30);
        repeat (run) begin
          @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_channel(string name, logic [yuvbgr_pkg::PixW-1:0] want,
                               logic [yuvbgr_pkg::PixW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin : pixel_check
    bgr_pair_t want;
    if (rst_ni && out_valid_o && out_stall_i) stalled_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual b%0d g%0d r%0d b%0d g%0d r%0d",
                 $time, blue_left_o, green_left_o, red_left_o,
                 blue_right_o, green_right_o, red_right_o);
        err_count++;
      end else begin
        want = pending_pixels.pop_front();
        received_count++;
        check_channel("blue_left", want.blue_l, blue_left_o);
        check_channel("green_left", want.green_l, green_left_o);
        check_channel("red_left", want.red_l, red_left_o);
        check_channel("blue_right", want.blue_r, blue_right_o);
        check_channel("green_right", want.green_r, green_right_o);
        check_channel("red_right", want.red_r, red_right_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d items still expected", $time, pending_pixels.size());
      $display("[yuv422_to_bgr_converter_core] ERROR");
      $finish;
    end
  end

endmodule
